// ===== sv/ppsch_pkg.sv =====
`default_nettype none
package ppsch_pkg;

    localparam int SLOTS  = 16;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

    typedef struct packed {
        logic [15:0] arrival;
        logic [15:0] remaining;
        logic [15:0] burst;
        logic [15:0] priority_lvl;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic              clear;
        logic              sample;
        logic [SLOT_W-1:0] slot;
    } t_scan_ctl;

endpackage
`default_nettype wire

// ===== sv/ppsch_ram.sv =====
`default_nettype none
module ppsch_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== sv/ppsch_best.sv =====
`default_nettype none
module ppsch_best (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire ppsch_pkg::t_scan_ctl       i_ctl,
    input  wire ppsch_pkg::t_entry          i_entry,
    input  wire logic [31:0]                i_time,
    output logic                            o_found,
    output logic [ppsch_pkg::SLOT_W-1:0]    o_slot,
    output ppsch_pkg::t_entry               o_entry
);
    import ppsch_pkg::*;

    logic              r_found;
    logic [SLOT_W-1:0] r_slot;
    t_entry            r_entry;
    logic              w_ready;
    logic              w_better;
    logic              n_take;

    // arrived and unfinished
    assign w_ready = (i_entry.remaining != 16'd0) && ({16'd0, i_entry.arrival} <= i_time);

    assign w_better = !r_found
        || (i_entry.priority_lvl < r_entry.priority_lvl)
        || ((i_entry.priority_lvl == r_entry.priority_lvl)
            && (i_entry.arrival < r_entry.arrival));

    assign n_take = i_ctl.sample && w_ready && w_better;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (n_take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_take && !i_ctl.clear) begin
            r_slot  <= i_ctl.slot;
            r_entry <= i_entry;
        end
    end

    assign o_found = r_found;
    assign o_slot  = r_slot;
    assign o_entry = r_entry;

endmodule
`default_nettype wire

// ===== sv/preemptive_priority_scheduler.sv =====
// preemptive priority scheduler over a table of process entries
// input channel (i_in_valid / o_in_ready): one word per item; i_kind 0 loads
// a process into the next free slot, i_kind 1 runs one time tick
// output channel (o_out_valid / i_out_ready): exactly one result word per item
// a load writes its result to the output register once that register is free
// a tick reads the loaded slots from the entry memory one per cycle, keeping
// the best ready entry, then writes it back with its remaining burst reduced
// by one; its result follows the scan of every loaded slot
// one item is in work at a time; the next is taken once the result is in the
// output register, so a held result does not block acceptance
// when the receiver stalls, the result holds and a finished item waits for
// the output register to free up before it updates state
// reset (synchronous, active low) empties the table and sets time to zero;
// the entry memory needs no clearing since only loaded slots are read
`default_nettype none
module preemptive_priority_scheduler (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_kind,
    input  wire logic [15:0] i_arrival_time,
    input  wire logic [15:0] i_burst_length,
    input  wire logic [15:0] i_priority_level,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_load_accepted,
    output logic             o_load_rejected,
    output logic [3:0]       o_slot_number,
    output logic             o_ran_valid,
    output logic             o_finished,
    output logic [31:0]      o_turnaround,
    output logic [31:0]      o_waiting,
    output logic [31:0]      o_current_time
);
    import ppsch_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [CNT_W-1:0]  r_count;
    logic [31:0]       r_time;
    logic [CNT_W-1:0]  r_rd_idx;
    logic              r_smp_valid;
    logic [SLOT_W-1:0] r_smp_slot;
    logic [15:0]       r_arr;
    logic [15:0]       r_bur;
    logic [15:0]       r_pri;

    logic              r_out_valid;
    logic              r_acc;
    logic              r_rej;
    logic [3:0]        r_slot;
    logic              r_ran;
    logic              r_fin;
    logic [31:0]       r_tat;
    logic [31:0]       r_wt;
    logic [31:0]       r_cur;

    logic              w_in_acc;
    logic              w_out_free;
    logic              w_rd_en;
    logic              w_load_ok;
    logic              w_we;
    logic [SLOT_W-1:0] w_waddr;
    t_entry            w_wdata;
    t_entry            w_load_entry;
    t_entry            w_best_upd;
    t_entry            w_rdata;
    t_scan_ctl         w_ctl;
    logic              w_found;
    logic [SLOT_W-1:0] w_best_slot;
    t_entry            w_best;
    logic [31:0]       n_time;
    logic [31:0]       w_tat;
    logic              w_done;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_rd_en    = (r_state == ST_SCAN) && (r_rd_idx < r_count);
    assign w_load_ok  = (r_count < SLOTS_CNT) && (r_bur != 16'd0);

    assign w_load_entry = '{arrival: r_arr, remaining: r_bur, burst: r_bur,
                            priority_lvl: r_pri};
    always_comb begin
        w_best_upd           = w_best;
        w_best_upd.remaining = w_best.remaining - 16'd1;
    end

    assign n_time = r_time + 32'd1;
    assign w_tat  = n_time - {16'd0, w_best.arrival};
    assign w_done = w_best.remaining == 16'd1;

    assign w_we = w_out_free && (((r_state == ST_LOAD) && w_load_ok)
                                 || ((r_state == ST_FIN) && w_found));
    assign w_waddr = (r_state == ST_LOAD) ? r_count[SLOT_W-1:0] : w_best_slot;
    assign w_wdata = (r_state == ST_LOAD) ? w_load_entry : w_best_upd;

    assign w_ctl.clear  = w_in_acc;
    assign w_ctl.sample = r_smp_valid;
    assign w_ctl.slot   = r_smp_slot;

    ppsch_ram #(
        .DEPTH (SLOTS),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_rd_en),
        .i_raddr (r_rd_idx[SLOT_W-1:0]),
        .o_rdata (w_rdata)
    );

    ppsch_best u_best (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_entry (w_rdata),
        .i_time  (r_time),
        .o_found (w_found),
        .o_slot  (w_best_slot),
        .o_entry (w_best)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = i_kind ? ST_SCAN : ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (!w_rd_en && !r_smp_valid) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_time      <= '0;
            r_rd_idx    <= '0;
            r_smp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_smp_valid <= w_rd_en;
            if (w_in_acc) begin
                r_rd_idx <= '0;
            end else if (w_rd_en) begin
                r_rd_idx <= r_rd_idx + CNT_W'(1);
            end
            if (r_state == ST_LOAD && w_out_free && w_load_ok) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (r_state == ST_FIN && w_out_free) begin
                r_time <= n_time;
            end
            if ((r_state == ST_LOAD || r_state == ST_FIN) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_smp_slot <= r_rd_idx[SLOT_W-1:0];
        if (w_in_acc) begin
            r_arr <= i_arrival_time;
            r_bur <= i_burst_length;
            r_pri <= i_priority_level;
        end
        if (r_state == ST_LOAD && w_out_free) begin
            r_acc  <= w_load_ok;
            r_rej  <= !w_load_ok;
            r_slot <= w_load_ok ? 4'(r_count[SLOT_W-1:0]) : 4'd0;
            r_ran  <= 1'b0;
            r_fin  <= 1'b0;
            r_tat  <= '0;
            r_wt   <= '0;
            r_cur  <= r_time;
        end else if (r_state == ST_FIN && w_out_free) begin
            r_acc  <= 1'b0;
            r_rej  <= 1'b0;
            r_slot <= w_found ? 4'(w_best_slot) : 4'd0;
            r_ran  <= w_found;
            r_fin  <= w_found && w_done;
            r_tat  <= (w_found && w_done) ? w_tat : 32'd0;
            r_wt   <= (w_found && w_done) ? (w_tat - {16'd0, w_best.burst}) : 32'd0;
            r_cur  <= n_time;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_load_accepted = r_acc;
    assign o_load_rejected = r_rej;
    assign o_slot_number   = r_slot;
    assign o_ran_valid     = r_ran;
    assign o_finished      = r_fin;
    assign o_turnaround    = r_tat;
    assign o_waiting       = r_wt;
    assign o_current_time  = r_cur;

endmodule
`default_nettype wire

// ===== sim/ppsch_checker.sv =====
`timescale 1ns / 1ps

package ppsch_tb_pkg;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_TICK = 1'b1
    } sched_kind_t;

endpackage

module ppsch_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic        i_kind,
    input  wire logic [15:0] i_arrival_time,
    input  wire logic [15:0] i_burst_length,
    input  wire logic [15:0] i_priority_level,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic        i_load_accepted,
    input  wire logic        i_load_rejected,
    input  wire logic [3:0]  i_slot_number,
    input  wire logic        i_ran_valid,
    input  wire logic        i_finished,
    input  wire logic [31:0] i_turnaround,
    input  wire logic [31:0] i_waiting,
    input  wire logic [31:0] i_current_time,
    output int               o_fail_count,
    output int               o_pending_count
);
    import ppsch_pkg::*;
    import ppsch_tb_pkg::*;

    typedef struct packed {
        logic        load_accepted;
        logic        load_rejected;
        logic [3:0]  slot_number;
        logic        ran_valid;
        logic        finished;
        logic [31:0] turnaround;
        logic [31:0] waiting;
        logic [31:0] current_time;
    } sched_result_t;

    logic        proc_valid     [SLOTS];
    logic [15:0] proc_arrival   [SLOTS];
    logic [15:0] proc_remaining [SLOTS];
    logic [15:0] proc_burst     [SLOTS];
    logic [15:0] proc_priority  [SLOTS];
    int unsigned procs_loaded;
    logic [31:0] sched_time;

    sched_result_t sched_results_q[$];

    // one scheduler step on the shadow table
    task automatic schedule_item(input logic kind, input logic [15:0] arr,
                                 input logic [15:0] bur, input logic [15:0] pri);
        sched_result_t r;
        int          best;
        bit          found;
        logic [31:0] span;
        r     = '0;
        best  = 0;
        found = 1'b0;
        if (kind == KIND_LOAD) begin
            if (procs_loaded >= SLOTS || bur == 16'd0) begin
                r.load_rejected = 1'b1;
            end else begin
                proc_valid[procs_loaded]     = 1'b1;
                proc_arrival[procs_loaded]   = arr;
                proc_remaining[procs_loaded] = bur;
                proc_burst[procs_loaded]     = bur;
                proc_priority[procs_loaded]  = pri;
                r.load_accepted = 1'b1;
                r.slot_number   = 4'(procs_loaded);
                procs_loaded    = procs_loaded + 1;
            end
        end else begin
            for (int i = 0; i < SLOTS; i++) begin
                if (proc_valid[i] && proc_remaining[i] != 16'd0 &&
                    {16'd0, proc_arrival[i]} <= sched_time) begin
                    if (!found || proc_priority[i] < proc_priority[best] ||
                        (proc_priority[i] == proc_priority[best] &&
                         proc_arrival[i] < proc_arrival[best])) begin
                        best  = i;
                        found = 1'b1;
                    end
                end
            end
            sched_time = sched_time + 32'd1;
            if (found) begin
                r.ran_valid          = 1'b1;
                r.slot_number        = 4'(best);
                proc_remaining[best] = proc_remaining[best] - 16'd1;
                if (proc_remaining[best] == 16'd0) begin
                    span         = sched_time - {16'd0, proc_arrival[best]};
                    r.finished   = 1'b1;
                    r.turnaround = span;
                    r.waiting    = span - {16'd0, proc_burst[best]};
                end
            end
        end
        r.current_time = sched_time;
        sched_results_q.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] got_val);
        if (exp_val !== got_val) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, got_val);
            o_fail_count = o_fail_count + 1;
        end
    endtask

    always @(posedge i_clk) begin
        sched_result_t e;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                proc_valid[i] = 1'b0;
            end
            procs_loaded = 0;
            sched_time   = 32'd0;
            o_fail_count = 0;
            sched_results_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (sched_results_q.size() == 0) begin
                    $display("%0t: result word with none expected, expected none, actual %0h",
                             $time, {i_load_accepted, i_load_rejected, i_slot_number,
                                     i_ran_valid, i_finished, i_turnaround,
                                     i_waiting, i_current_time});
                    o_fail_count = o_fail_count + 1;
                end else begin
                    e = sched_results_q.pop_front();
                    check_field("load_accepted", 32'(e.load_accepted), 32'(i_load_accepted));
                    check_field("load_rejected", 32'(e.load_rejected), 32'(i_load_rejected));
                    check_field("slot_number", 32'(e.slot_number), 32'(i_slot_number));
                    check_field("ran_valid", 32'(e.ran_valid), 32'(i_ran_valid));
                    check_field("finished", 32'(e.finished), 32'(i_finished));
                    check_field("turnaround", e.turnaround, i_turnaround);
                    check_field("waiting", e.waiting, i_waiting);
                    check_field("current_time", e.current_time, i_current_time);
                end
            end
            if (i_in_valid && i_in_ready) begin
                schedule_item(i_kind, i_arrival_time, i_burst_length, i_priority_level);
            end
        end
        o_pending_count = sched_results_q.size();
    end

endmodule

// ===== sim/tb_preemptive_priority_scheduler.sv =====
`timescale 1ns / 1ps

module tb_preemptive_priority_scheduler;
    import ppsch_tb_pkg::*;

    localparam int RANDOM_ITEMS = 450;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 60;

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_in_valid       = 1'b0;
    logic        i_kind           = 1'b0;
    logic [15:0] i_arrival_time   = 16'd0;
    logic [15:0] i_burst_length   = 16'd0;
    logic [15:0] i_priority_level = 16'd0;
    logic        i_out_ready      = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_load_accepted;
    logic        o_load_rejected;
    logic [3:0]  o_slot_number;
    logic        o_ran_valid;
    logic        o_finished;
    logic [31:0] o_turnaround;
    logic [31:0] o_waiting;
    logic [31:0] o_current_time;

    int fail_count;
    int pending_count;
    int cycle_count  = 0;
    int burst_left   = 0;
    int ticks_sent   = 0;
    int ready_mode   = 0;
    int ready_phase  = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    preemptive_priority_scheduler dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_kind           (i_kind),
        .i_arrival_time   (i_arrival_time),
        .i_burst_length   (i_burst_length),
        .i_priority_level (i_priority_level),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_load_accepted  (o_load_accepted),
        .o_load_rejected  (o_load_rejected),
        .o_slot_number    (o_slot_number),
        .o_ran_valid      (o_ran_valid),
        .o_finished       (o_finished),
        .o_turnaround     (o_turnaround),
        .o_waiting        (o_waiting),
        .o_current_time   (o_current_time)
    );

    ppsch_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_kind           (i_kind),
        .i_arrival_time   (i_arrival_time),
        .i_burst_length   (i_burst_length),
        .i_priority_level (i_priority_level),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_load_accepted  (o_load_accepted),
        .i_load_rejected  (o_load_rejected),
        .i_slot_number    (o_slot_number),
        .i_ran_valid      (o_ran_valid),
        .i_finished       (o_finished),
        .i_turnaround     (o_turnaround),
        .i_waiting        (o_waiting),
        .i_current_time   (o_current_time),
        .o_fail_count     (fail_count),
        .o_pending_count  (pending_count)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver stall pattern; the mode is redrawn at random each time ready_phase wraps to zero
    always @(posedge i_clk) begin
        if (ready_phase == 0) begin
            ready_mode = $urandom_range(0, 3);
        end
        ready_phase = (ready_phase + 1) % 48;
        case (ready_mode)
            0: begin
                i_out_ready <= 1'b1;
            end
            1: begin
                i_out_ready <= 1'($urandom_range(0, 1));
            end
            2: begin
                i_out_ready <= (ready_phase % 6) < 4;
            end
            default: begin
                i_out_ready <= (ready_phase % 16) == 15;
            end
        endcase
    end

    // sender gaps between bursts of words
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left = burst_left - 1;
        end else begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_word(input sched_kind_t kind, input logic [15:0] arr,
                             input logic [15:0] bur, input logic [15:0] pri);
        i_in_valid       <= 1'b1;
        i_kind           <= kind;
        i_arrival_time   <= arr;
        i_burst_length   <= bur;
        i_priority_level <= pri;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        if (kind == KIND_TICK) begin
            ticks_sent = ticks_sent + 1;
        end
        pace_sender();
    endtask

    initial begin
        logic [15:0] arr;
        logic [15:0] bur;
        logic [15:0] pri;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle tick on empty table
        send_word(KIND_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // zero burst rejected
        send_word(KIND_LOAD, 16'hFFFF, 16'd0, 16'd0);
        // equal priority and arrival, lower slot wins
        send_word(KIND_LOAD, 16'd0, 16'd2, 16'd5);
        send_word(KIND_LOAD, 16'd0, 16'd1, 16'd5);
        // equal priority, later arrival loses
        send_word(KIND_LOAD, 16'd1, 16'd1, 16'd5);
        // background entry, always ready, never finishes here
        send_word(KIND_LOAD, 16'd0, 16'hFFFF, 16'hFFFF);
        // never arrives
        send_word(KIND_LOAD, 16'hFFFF, 16'd1, 16'd0);
        // preempts at time 4
        send_word(KIND_LOAD, 16'd4, 16'd3, 16'd0);
        repeat (10) send_word(KIND_TICK, 16'd0, 16'd0, 16'd0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 11) == 0) begin
                arr = ($urandom_range(0, 3) != 0) ?
                      16'(ticks_sent + $urandom_range(0, 12)) : 16'($urandom_range(0, 65535));
                case ($urandom_range(0, 9))
                    0:       bur = 16'd0;
                    1:       bur = 16'($urandom_range(0, 65535));
                    default: bur = 16'($urandom_range(1, 6));
                endcase
                pri = ($urandom_range(0, 3) != 0) ?
                      16'($urandom_range(0, 7)) : 16'($urandom_range(0, 65535));
                send_word(KIND_LOAD, arr, bur, pri);
            end else begin
                send_word(KIND_TICK, 16'($urandom_range(0, 65535)),
                          16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            end
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
